// ----- design/fcz_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fcz_pkg
// Shared types and constants of the frame tint and zoom sequencer.
// ----------------------------------------------------------------------------
package fcz_pkg;

  localparam int unsigned FADE_DEFAULT = 30;
  localparam int unsigned ZOOM_DEFAULT = 256;

  // command codes carried in the func field
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_BLEND = 2'd1;
  localparam logic [1:0] FUNC_DIM   = 2'd2;
  localparam logic [1:0] FUNC_ZOOM  = 2'd3;

  localparam logic [7:0] DIM_LOW  = 8'd160;
  localparam logic [7:0] DIM_HIGH = 8'd255;
  localparam logic [7:0] DIM_STEP = 8'd4;

  localparam logic [1:0] CHAN_LAST = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [15:0]        hold_frames;
    logic               dim_flag;
    logic [15:0]        zoom_target;
    logic signed [15:0] zoom_speed;
  } fcz_req_t;

  typedef struct packed {
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [15:0] zoom_now;
    logic        fading;
  } fcz_rsp_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_APPLY,
    OP_PREP,
    OP_QMUL,
    OP_QFIX,
    OP_ASET,
    OP_MIX0,
    OP_MIX1,
    OP_SUM,
    OP_SCALE,
    OP_STORE,
    OP_LOAD
  } fcz_op_e;

  typedef struct packed {
    fcz_op_e    op;
    logic [1:0] chan;
  } fcz_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic fl_zero;
    logic plain;
  } fcz_status_t;

endpackage
`default_nettype wire

// ----- design/fcz_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fcz_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface fcz_req_if;
  import fcz_pkg::*;
  logic     valid;
  logic     ready;
  fcz_req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface fcz_rsp_if;
  import fcz_pkg::*;
  logic     valid;
  logic     ready;
  fcz_rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- design/frame_color_fade_and_zoom_top.sv -----
// A word is accepted only while the sequencer is idle: a non-tick word is applied
// and loaded, a tick steps an idle tint, the hold phase or a fade, and the load
// waits until the result register is free. The single shared multiplier forms
// three products per colour channel, two more for the fade fraction.
// Reset: asynchronous, active low; clears the sequencer to black tint, default
// zoom and full dimming level, with no clearing pass.
`default_nettype none
// ----------------------------------------------------------------------------
// frame_color_fade_and_zoom_top
// Per-frame tint crossfade, dimming and zoom stepping sequencer.
// ----------------------------------------------------------------------------
module frame_color_fade_and_zoom_top #(
  parameter int unsigned FADE         = fcz_pkg::FADE_DEFAULT,
  parameter int unsigned DEFAULT_ZOOM = fcz_pkg::ZOOM_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fcz_req_if.sink    req_i,
  fcz_rsp_if.source  rsp_o
);
  import fcz_pkg::*;

  fcz_cmd_t    cmd;
  fcz_status_t status;

  fcz_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .rsp_ready_i (rsp_o.ready),
    .status_i    (status),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .cmd_o       (cmd)
  );

  fcz_dp #(
    .FADE         (FADE),
    .DEFAULT_ZOOM (DEFAULT_ZOOM)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .req_i    (req_i.payload),
    .status_o (status),
    .rsp_o    (rsp_o.payload)
  );

`ifndef SYNTHESIS
  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_LOAD |=> rsp_o.valid)
    else $error("result word not presented after load");

  a_apply_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.payload.func != FUNC_TICK) |->
      cmd.op == OP_APPLY)
    else $error("accepted command word not applied");

  a_prep_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_PREP |-> $past(req_i.valid && req_i.ready))
    else $error("tick started without an accepted word");

  a_store_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_STORE |=> (cmd.op == OP_MIX0 || cmd.op == OP_LOAD ||
                            cmd.op == OP_NONE))
    else $error("unexpected step after channel store");
`endif

endmodule
`default_nettype wire

// ----- design/fcz_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fcz_ctrl
// Sequencer: steps the shared multiplier through the fade fraction and the
// three colour channels, and owns the result word's valid flag.
// ----------------------------------------------------------------------------
module fcz_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                rsp_ready_i,
  input  fcz_pkg::fcz_status_t status_i,
  output logic                req_ready_o,
  output logic                rsp_valid_o,
  output fcz_pkg::fcz_cmd_t   cmd_o
);
  import fcz_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PREP  = 4'd1;
  localparam logic [3:0] ST_QMUL  = 4'd2;
  localparam logic [3:0] ST_QFIX  = 4'd3;
  localparam logic [3:0] ST_ASET  = 4'd4;
  localparam logic [3:0] ST_MIX0  = 4'd5;
  localparam logic [3:0] ST_MIX1  = 4'd6;
  localparam logic [3:0] ST_SUM   = 4'd7;
  localparam logic [3:0] ST_SCALE = 4'd8;
  localparam logic [3:0] ST_STORE = 4'd9;
  localparam logic [3:0] ST_DONE  = 4'd10;

  logic [3:0] state_q, state_d;
  logic [1:0] chan_q, chan_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    chan_d      = chan_q;
    out_valid_d = out_valid_q && !rsp_ready_i;
    cmd_o.op    = OP_NONE;
    cmd_o.chan  = chan_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          if (status_i.is_tick) begin
            state_d = ST_PREP;
          end else begin
            cmd_o.op = OP_APPLY;
            state_d  = ST_DONE;
          end
        end
      end
      ST_PREP: begin
        cmd_o.op = OP_PREP;
        chan_d   = 2'd0;
        if (status_i.fl_zero) begin
          state_d = ST_DONE;
        end else if (status_i.plain) begin
          state_d = ST_MIX0;
        end else begin
          state_d = ST_QMUL;
        end
      end
      ST_QMUL: begin
        cmd_o.op = OP_QMUL;
        state_d  = ST_QFIX;
      end
      ST_QFIX: begin
        cmd_o.op = OP_QFIX;
        state_d  = ST_ASET;
      end
      ST_ASET: begin
        cmd_o.op = OP_ASET;
        state_d  = ST_MIX0;
      end
      ST_MIX0: begin
        cmd_o.op = OP_MIX0;
        state_d  = ST_MIX1;
      end
      ST_MIX1: begin
        cmd_o.op = OP_MIX1;
        state_d  = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.op = OP_SUM;
        state_d  = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.op = OP_SCALE;
        state_d  = ST_STORE;
      end
      ST_STORE: begin
        cmd_o.op = OP_STORE;
        if (chan_q == CHAN_LAST) begin
          state_d = ST_DONE;
        end else begin
          chan_d  = chan_q + 2'd1;
          state_d = ST_MIX0;
        end
      end
      ST_DONE: begin
        // hold until the result register is free or being emptied
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.op    = OP_LOAD;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chan_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chan_q      <= chan_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- design/fcz_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fcz_dp
// Datapath: sequencer state, one shared 17x17 multiplier with a product
// register, divide-by-255 correction and the result register.
// ----------------------------------------------------------------------------
module fcz_dp #(
  parameter int unsigned FADE         = fcz_pkg::FADE_DEFAULT,
  parameter int unsigned DEFAULT_ZOOM = fcz_pkg::ZOOM_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fcz_pkg::fcz_cmd_t    cmd_i,
  input  fcz_pkg::fcz_req_t    req_i,
  output fcz_pkg::fcz_status_t status_o,
  output fcz_pkg::fcz_rsp_t    rsp_o
);
  import fcz_pkg::*;

  localparam logic [16:0] FADE_W   = 17'(FADE);
  localparam logic [16:0] RECIP    = 17'(65536 / FADE);
  localparam logic [16:0] RUN_RST  = 17'(2 * FADE);
  localparam logic [15:0] ZOOM_RST = 16'(DEFAULT_ZOOM);

  function automatic logic [7:0] pick(input logic [23:0] rgb, input logic [1:0] ch);
    logic [7:0] v;
    case (ch)
      2'd1:    v = rgb[15:8];
      2'd2:    v = rgb[23:16];
      default: v = rgb[7:0];
    endcase
    return v;
  endfunction

  // x / 255 for x below 65536: estimate from x * 257 / 65536, then one fix-up
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    logic [8:0]  est;
    logic [16:0] back;
    logic [16:0] rem;
    sum  = {1'b0, x} + {9'd0, x[15:8]};
    est  = sum[16:8];
    back = {est, 8'd0} - {8'd0, est};
    rem  = {1'b0, x} - back;
    if (rem >= 17'd255) begin
      est = est + 9'd1;
    end
    return est[7:0];
  endfunction

  // architectural state
  logic [23:0]        goal_q, from_q, tint_q;
  logic [16:0]        rl_q, fl_q;
  logic [7:0]         dim_q;
  logic               dim_on_q;
  logic [15:0]        zoom_cur_q, zoom_goal_q;
  logic signed [16:0] zoom_step_q;

  // working registers
  logic [15:0] n_q;
  logic [7:0]  a_q;
  logic        white_q;
  logic [33:0] prod_q;
  logic [15:0] acc_q;
  logic [7:0]  q255_q;
  fcz_rsp_t    out_q;

  logic               fl_zero, in_tail, in_head, plain;
  logic [16:0]        head_gap;
  logic [7:0]         n_base;
  logic [15:0]        n_d;
  logic [7:0]         dim_next;
  logic signed [17:0] zsum, zgoal_s, zsel;
  logic               snap;
  logic [15:0]        zoom_next;
  logic [15:0]        ztarget;
  logic [16:0]        speed_ext, speed_mag;
  logic signed [16:0] step_set;
  logic [16:0]        run_set;
  logic [7:0]         g_k, from_k, q_est;
  logic [16:0]        mul_a, mul_b;
  logic [33:0]        mult;
  logic [15:0]        rem_a;
  logic [15:0]        mix_sum;

  assign fl_zero  = (fl_q == 17'd0);
  assign in_tail  = !fl_zero && (fl_q < FADE_W);
  assign in_head  = (rl_q >= FADE_W) && (fl_q > (rl_q - FADE_W)) && (rl_q >= fl_q);
  assign plain    = !fl_zero && !in_tail && !in_head;
  assign head_gap = rl_q - fl_q;
  assign n_base   = in_tail ? fl_q[7:0] : head_gap[7:0];
  assign n_d      = {n_base, 8'd0} - {8'd0, n_base};

  always_comb begin
    if (dim_on_q) begin
      dim_next = (dim_q >= DIM_LOW + DIM_STEP) ? dim_q - DIM_STEP : DIM_LOW;
    end else begin
      dim_next = (dim_q <= DIM_HIGH - DIM_STEP) ? dim_q + DIM_STEP : DIM_HIGH;
    end
  end

  // zoom advance: wide sum, snap to goal on reaching it, clamp to 16 bits
  assign zsum    = $signed({2'b00, zoom_cur_q}) + $signed({zoom_step_q[16], zoom_step_q});
  assign zgoal_s = $signed({2'b00, zoom_goal_q});
  assign snap    = ((zoom_step_q < 0) && (zsum <= zgoal_s)) ||
                   ((zoom_step_q > 0) && (zsum >= zgoal_s));
  assign zsel    = snap ? zgoal_s : zsum;

  always_comb begin
    if (zsel < 0) begin
      zoom_next = 16'd0;
    end else if (zsel > $signed(18'd65535)) begin
      zoom_next = 16'hFFFF;
    end else begin
      zoom_next = zsel[15:0];
    end
  end

  assign ztarget   = (req_i.zoom_target == 16'd0) ? 16'd1 : req_i.zoom_target;
  assign speed_ext = {req_i.zoom_speed[15], req_i.zoom_speed};
  assign speed_mag = req_i.zoom_speed[15] ? (17'd0 - speed_ext) : speed_ext;
  assign step_set  = (ztarget < zoom_cur_q) ? $signed(17'd0 - speed_mag)
                                             : $signed(speed_mag);
  assign run_set   = {1'b0, req_i.hold_frames} + RUN_RST;

  assign g_k    = pick(goal_q, cmd_i.chan);
  assign from_k = white_q ? 8'hFF : pick(from_q, cmd_i.chan);
  assign q_est  = prod_q[23:16];

  always_comb begin
    case (cmd_i.op)
      OP_QMUL: begin
        mul_a = {1'b0, n_q};
        mul_b = RECIP;
      end
      OP_QFIX: begin
        mul_a = {9'd0, q_est};
        mul_b = FADE_W;
      end
      OP_MIX0: begin
        mul_a = {9'd0, g_k};
        mul_b = {9'd0, a_q};
      end
      OP_MIX1: begin
        mul_a = {9'd0, from_k};
        mul_b = {9'd0, 8'hFF - a_q};
      end
      OP_SCALE: begin
        mul_a = {9'd0, q255_q};
        mul_b = {9'd0, dim_q} + 17'd1;
      end
      default: begin
        mul_a = 17'd0;
        mul_b = 17'd0;
      end
    endcase
  end

  assign mult    = mul_a * mul_b;
  assign rem_a   = n_q - prod_q[15:0];
  assign mix_sum = acc_q + prod_q[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_q      <= 24'd0;
      from_q      <= 24'd0;
      tint_q      <= 24'd0;
      rl_q        <= RUN_RST;
      fl_q        <= FADE_W;
      dim_q       <= DIM_HIGH;
      dim_on_q    <= 1'b0;
      zoom_cur_q  <= ZOOM_RST;
      zoom_goal_q <= ZOOM_RST;
      zoom_step_q <= '0;
    end else begin
      case (cmd_i.op)
        OP_APPLY: begin
          case (req_i.func)
            FUNC_BLEND: begin
              goal_q <= {req_i.blue, req_i.green, req_i.red};
              from_q <= tint_q;
              rl_q   <= run_set;
              fl_q   <= run_set;
            end
            FUNC_DIM: begin
              dim_on_q <= req_i.dim_flag;
            end
            FUNC_ZOOM: begin
              zoom_goal_q <= ztarget;
              zoom_step_q <= step_set;
            end
            default: ;
          endcase
        end
        OP_PREP: begin
          dim_q <= dim_next;
          if (fl_zero) begin
            tint_q <= {dim_next, dim_next, dim_next};
          end else begin
            fl_q <= fl_q - 17'd1;
          end
          if (zoom_step_q != 0) begin
            zoom_cur_q <= zoom_next;
            if (snap) begin
              zoom_step_q <= '0;
            end
          end
        end
        OP_STORE: begin
          case (cmd_i.chan)
            2'd1:    tint_q[15:8]  <= prod_q[15:8];
            2'd2:    tint_q[23:16] <= prod_q[15:8];
            default: tint_q[7:0]   <= prod_q[15:8];
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mult;
    case (cmd_i.op)
      OP_PREP: begin
        n_q     <= n_d;
        white_q <= in_tail;
        a_q     <= 8'hFF;
      end
      OP_QFIX: a_q <= q_est;
      OP_ASET: begin
        if (rem_a >= FADE_W[15:0]) begin
          a_q <= a_q + 8'd1;
        end
      end
      OP_MIX1: acc_q  <= prod_q[15:0];
      OP_SUM:  q255_q <= div255(mix_sum);
      OP_LOAD: begin
        out_q.out_red   <= tint_q[7:0];
        out_q.out_green <= tint_q[15:8];
        out_q.out_blue  <= tint_q[23:16];
        out_q.zoom_now  <= zoom_cur_q;
        out_q.fading    <= !fl_zero;
      end
      default: ;
    endcase
  end

  assign status_o.is_tick = (req_i.func == FUNC_TICK);
  assign status_o.fl_zero = fl_zero;
  assign status_o.plain   = plain;
  assign rsp_o            = out_q;

endmodule
`default_nettype wire
